// ===== rtl/odo_pkg.sv =====
// Shared types, constants and helpers for the odometry block.
// No dependencies; used by every module of the block.
package odo_pkg;

    // Configuration register indexes
    localparam logic [7:0] CFG_WHEEL_GAIN = 8'd0;
    localparam logic [7:0] CFG_HALF_TRACK = 8'd1;

    // Configuration reset values
    localparam logic [31:0] WHEEL_GAIN_RST = 32'd47258813;
    localparam logic [31:0] HALF_TRACK_RST = 32'd83886080;

    // Time scale constants: seconds per microsecond in Q0.32, and
    // rad/s times microseconds to binary angle in Q0.32
    localparam logic [39:0] US_TO_S_Q32  = 40'd4295;
    localparam logic [39:0] RAD_US_TO_BA = 40'd44798134;

    // CORDIC constants, Q1.30 and binary angle, 34-bit signed
    localparam logic signed [33:0] CORDIC_ONE   = 34'sd652032874;
    localparam logic signed [33:0] QUARTER_TURN = 34'sd1073741824;
    localparam logic signed [33:0] HALF_TURN    = 34'sd2147483648;

    // Shared multiplier widths
    localparam int MUL_A_W = 56;
    localparam int MUL_B_W = 40;
    localparam int PROD_W  = 96;

    typedef struct packed {
        logic signed [15:0] left_wheel_speed;
        logic signed [15:0] right_wheel_speed;
        logic [19:0]        elapsed_us;
    } t_in;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [31:0]        heading_angle;
        logic signed [31:0] forward_speed;
        logic signed [31:0] turn_rate;
    } t_out;

    // Multiplier operations in issue order
    typedef enum logic [3:0] {
        OP_PL  = 4'd0,
        OP_PR  = 4'd1,
        OP_TR  = 4'd2,
        OP_VC  = 4'd3,
        OP_VS  = 4'd4,
        OP_DXU = 4'd5,
        OP_DYU = 4'd6,
        OP_THU = 4'd7,
        OP_DX  = 4'd8,
        OP_DY  = 4'd9,
        OP_TH  = 4'd10
    } t_op;

    typedef struct packed {
        logic load;
        logic mul_start;
        logic commit;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic trig_done;
        logic out_free;
    } t_sts;

    // Saturate to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [95:0] v);
        logic signed [31:0] r;
        if (v > 96'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -96'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Arctangent of 2^-i as binary angle
    function automatic logic [31:0] atan_ba(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA;
            5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30;
            5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C;
            5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3;
            5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000029;
            5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A;
            5'd27: r = 32'h00000005;
            5'd28: r = 32'h00000003;
            5'd29: r = 32'h00000001;
            5'd30: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/odo_mul.sv =====
// Shared signed multiplier, one 8-bit digit of the second operand per cycle.
// Depends on odo_pkg for operand and product widths.
module odo_mul (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [odo_pkg::MUL_A_W-1:0]   i_a,
    input  logic signed [odo_pkg::MUL_B_W-1:0]   i_b,
    output logic                                 o_done,
    output logic signed [odo_pkg::PROD_W-1:0]    o_prod
);

    logic signed [odo_pkg::MUL_A_W-1:0] r_a;
    logic signed [odo_pkg::MUL_B_W-1:0] r_b;
    logic signed [odo_pkg::PROD_W-1:0]  r_acc;
    logic [2:0]                         r_cnt;
    logic                               r_busy;
    logic                               r_done;
    logic signed [8:0]                  digit;
    logic signed [64:0]                 pp;

    // Pick the digit, top one signed, the rest unsigned
    always_comb begin
        case (r_cnt)
            3'd4:    digit = $signed({r_b[39], r_b[39:32]});
            3'd3:    digit = $signed({1'b0, r_b[31:24]});
            3'd2:    digit = $signed({1'b0, r_b[23:16]});
            3'd1:    digit = $signed({1'b0, r_b[15:8]});
            3'd0:    digit = $signed({1'b0, r_b[7:0]});
            default: digit = 9'sd0;
        endcase
        pp = r_a * digit;
    end

    // Control: run five digit steps, then flag the product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 3'd4;
            end else if (r_busy) begin
                if (r_cnt == 3'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 3'd1;
                end
            end
        end
    end

    // Datapath: shift the sum up a digit and add the partial product
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= (r_acc <<< 8) + odo_pkg::PROD_W'(pp);
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ===== rtl/odo_cordic.sv =====
// Iterative rotation-mode CORDIC giving cosine and sine of a binary angle.
// Depends on odo_pkg for the arctangent table and fixed constants.
module odo_cordic #(
    parameter int TRIG_ITERATIONS = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [31:0]        i_angle,
    output logic               o_done,
    output logic signed [33:0] o_cos,
    output logic signed [33:0] o_sin
);

    localparam int CNT_W = (TRIG_ITERATIONS > 1) ? $clog2(TRIG_ITERATIONS) : 1;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(TRIG_ITERATIONS - 1);

    logic signed [33:0] r_x, r_y, r_z;
    logic               r_neg;
    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic signed [33:0] z0, zf, dx, dy, at;
    logic               negf;

    // Fold the angle into a quarter turn either side of zero
    always_comb begin
        z0   = 34'($signed(i_angle));
        zf   = z0;
        negf = 1'b0;
        if (z0 > odo_pkg::QUARTER_TURN) begin
            zf   = z0 - odo_pkg::HALF_TURN;
            negf = 1'b1;
        end else if (z0 < -odo_pkg::QUARTER_TURN) begin
            zf   = z0 + odo_pkg::HALF_TURN;
            negf = 1'b1;
        end
    end

    // One micro-rotation
    always_comb begin
        dx = r_y >>> r_cnt;
        dy = r_x >>> r_cnt;
        at = $signed({2'b00, odo_pkg::atan_ba(5'(r_cnt))});
    end

    // Control: count iterations, hold done until the next start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            if (r_cnt == LAST) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // Rotate towards zero residual angle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= odo_pkg::CORDIC_ONE;
            r_y   <= '0;
            r_z   <= zf;
            r_neg <= negf;
        end else if (r_busy) begin
            if (!r_z[33]) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + at;
            end
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_neg ? -r_x : r_x;
    assign o_sin  = r_neg ? -r_y : r_y;

endmodule

// ===== rtl/odo_datapath.sv =====
// Odometry datapath: configuration, operand selection, intermediates, pose.
// Depends on odo_pkg, odo_mul and odo_cordic.
module odo_datapath #(
    parameter int SPEED_BITS      = 16,
    parameter int TRIG_ITERATIONS = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  odo_pkg::t_cmd i_cmd,
    output odo_pkg::t_sts o_sts,
    input  odo_pkg::t_in  i_in,
    input  logic          i_cfg_we,
    input  logic [7:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output odo_pkg::t_out o_out
);

    localparam int CNT_W = (SPEED_BITS < 16) ? SPEED_BITS : 16;
    localparam int SH    = 16 - CNT_W;

    logic [31:0]        r_gain, r_htr;
    logic signed [15:0] r_cl, r_cr;
    logic [19:0]        r_us;
    logic signed [47:0] r_pl, r_pr;
    logic signed [31:0] r_fwd, r_tr;
    logic signed [33:0] r_vc, r_vs;
    logic signed [54:0] r_px, r_py, r_pt;
    logic signed [35:0] r_dx, r_dy;
    logic [31:0]        r_dth;
    logic signed [31:0] r_x, r_y;
    logic [31:0]        r_h;
    logic               r_out_valid;
    odo_pkg::t_out      r_out;

    logic signed [15:0] tl, tr16, n_cl, n_cr;
    logic signed [48:0] sum, dif;
    logic signed [31:0] fwd_c, hd_c;
    logic signed [odo_pkg::MUL_A_W-1:0] mul_a;
    logic signed [odo_pkg::MUL_B_W-1:0] mul_b;
    logic signed [odo_pkg::PROD_W-1:0]  prod;
    logic signed [odo_pkg::PROD_W-1:0]  sh24, sh30, sh32;
    logic               mul_done, trig_done;
    logic signed [33:0] cs, sn;
    logic signed [31:0] n_x, n_y;
    logic [31:0]        n_h;

    // Keep only the low count bits, sign-extended
    always_comb begin
        tl   = i_in.left_wheel_speed <<< SH;
        tr16 = i_in.right_wheel_speed <<< SH;
        n_cl = tl >>> SH;
        n_cr = tr16 >>> SH;
    end

    // Forward speed and half difference from the wheel products
    always_comb begin
        sum   = 49'(r_pl) + 49'(r_pr);
        dif   = 49'(r_pr) - 49'(r_pl);
        fwd_c = odo_pkg::sat32(96'(sum >>> 17));
        hd_c  = odo_pkg::sat32(96'(dif >>> 17));
    end

    // Select multiplier operands by operation
    always_comb begin
        case (i_cmd.op)
            odo_pkg::OP_PL: begin
                mul_a = 56'(r_cl);
                mul_b = $signed({8'b0, r_gain});
            end
            odo_pkg::OP_PR: begin
                mul_a = 56'(r_cr);
                mul_b = $signed({8'b0, r_gain});
            end
            odo_pkg::OP_TR: begin
                mul_a = 56'(hd_c);
                mul_b = $signed({8'b0, r_htr});
            end
            odo_pkg::OP_VC: begin
                mul_a = 56'(r_fwd);
                mul_b = 40'(cs);
            end
            odo_pkg::OP_VS: begin
                mul_a = 56'(r_fwd);
                mul_b = 40'(sn);
            end
            odo_pkg::OP_DXU: begin
                mul_a = 56'(r_vc);
                mul_b = $signed({20'b0, r_us});
            end
            odo_pkg::OP_DYU: begin
                mul_a = 56'(r_vs);
                mul_b = $signed({20'b0, r_us});
            end
            odo_pkg::OP_THU: begin
                mul_a = 56'(r_tr);
                mul_b = $signed({20'b0, r_us});
            end
            odo_pkg::OP_DX: begin
                mul_a = 56'(r_px);
                mul_b = $signed(odo_pkg::US_TO_S_Q32);
            end
            odo_pkg::OP_DY: begin
                mul_a = 56'(r_py);
                mul_b = $signed(odo_pkg::US_TO_S_Q32);
            end
            odo_pkg::OP_TH: begin
                mul_a = 56'(r_pt);
                mul_b = $signed(odo_pkg::RAD_US_TO_BA);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    odo_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (prod)
    );

    odo_cordic #(
        .TRIG_ITERATIONS (TRIG_ITERATIONS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.load),
        .i_angle (r_h),
        .o_done  (trig_done),
        .o_cos   (cs),
        .o_sin   (sn)
    );

    always_comb begin
        sh24 = prod >>> 24;
        sh30 = prod >>> 30;
        sh32 = prod >>> 32;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= odo_pkg::WHEEL_GAIN_RST;
            r_htr  <= odo_pkg::HALF_TRACK_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                odo_pkg::CFG_WHEEL_GAIN: r_gain <= i_cfg_data;
                odo_pkg::CFG_HALF_TRACK: r_htr  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Capture the item and the intermediate products
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cl <= n_cl;
            r_cr <= n_cr;
            r_us <= i_in.elapsed_us;
        end
        if (i_cmd.mul_start && i_cmd.op == odo_pkg::OP_TR) begin
            r_fwd <= fwd_c;
        end
        if (mul_done) begin
            case (i_cmd.op)
                odo_pkg::OP_PL:  r_pl  <= prod[47:0];
                odo_pkg::OP_PR:  r_pr  <= prod[47:0];
                odo_pkg::OP_TR:  r_tr  <= odo_pkg::sat32(sh24);
                odo_pkg::OP_VC:  r_vc  <= sh30[33:0];
                odo_pkg::OP_VS:  r_vs  <= sh30[33:0];
                odo_pkg::OP_DXU: r_px  <= prod[54:0];
                odo_pkg::OP_DYU: r_py  <= prod[54:0];
                odo_pkg::OP_THU: r_pt  <= prod[54:0];
                odo_pkg::OP_DX:  r_dx  <= sh32[35:0];
                odo_pkg::OP_DY:  r_dy  <= sh32[35:0];
                odo_pkg::OP_TH:  r_dth <= sh32[31:0];
                default: ;
            endcase
        end
    end

    // Next pose: saturate the position, wrap the heading
    always_comb begin
        n_x = odo_pkg::sat32(96'(r_x) + 96'(r_dx));
        n_y = odo_pkg::sat32(96'(r_y) + 96'(r_dy));
        n_h = r_h + r_dth;
    end

    // Pose state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x         <= '0;
            r_y         <= '0;
            r_h         <= '0;
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_x         <= n_x;
            r_y         <= n_y;
            r_h         <= n_h;
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out.pos_x         <= n_x;
            r_out.pos_y         <= n_y;
            r_out.heading_angle <= n_h;
            r_out.forward_speed <= r_fwd;
            r_out.turn_rate     <= r_tr;
        end
    end

    assign o_sts.mul_done  = mul_done;
    assign o_sts.trig_done = trig_done;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out           = r_out;

endmodule

// ===== rtl/odo_ctrl.sv =====
// Odometry controller: sequences the multiplier operations of one item.
// Depends on odo_pkg for the command, status and operation types.
module odo_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  odo_pkg::t_sts i_sts,
    output odo_pkg::t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_ISSUE  = 4'b0010,
        S_BUSY   = 4'b0100,
        S_COMMIT = 4'b1000
    } t_state;

    t_state       r_state, n_state;
    odo_pkg::t_op r_op, n_op, op_next;

    // Following operation in issue order
    always_comb begin
        case (r_op)
            odo_pkg::OP_PL:  op_next = odo_pkg::OP_PR;
            odo_pkg::OP_PR:  op_next = odo_pkg::OP_TR;
            odo_pkg::OP_TR:  op_next = odo_pkg::OP_VC;
            odo_pkg::OP_VC:  op_next = odo_pkg::OP_VS;
            odo_pkg::OP_VS:  op_next = odo_pkg::OP_DXU;
            odo_pkg::OP_DXU: op_next = odo_pkg::OP_DYU;
            odo_pkg::OP_DYU: op_next = odo_pkg::OP_THU;
            odo_pkg::OP_THU: op_next = odo_pkg::OP_DX;
            odo_pkg::OP_DX:  op_next = odo_pkg::OP_DY;
            odo_pkg::OP_DY:  op_next = odo_pkg::OP_TH;
            default:         op_next = odo_pkg::OP_PL;
        endcase
    end

    // Advance the sequence
    always_comb begin
        n_state         = r_state;
        n_op            = r_op;
        o_cmd.load      = 1'b0;
        o_cmd.mul_start = 1'b0;
        o_cmd.commit    = 1'b0;
        o_cmd.op        = r_op;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_op       = odo_pkg::OP_PL;
                    n_state    = S_ISSUE;
                end
            end
            S_ISSUE: begin
                // the speed products need the cosine and sine first
                if (r_op != odo_pkg::OP_VC || i_sts.trig_done) begin
                    o_cmd.mul_start = 1'b1;
                    n_state         = S_BUSY;
                end
            end
            S_BUSY: begin
                if (i_sts.mul_done) begin
                    if (r_op == odo_pkg::OP_TH) begin
                        n_state = S_COMMIT;
                    end else begin
                        n_op    = op_next;
                        n_state = S_ISSUE;
                    end
                end
            end
            S_COMMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= odo_pkg::OP_PL;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// ===== rtl/diff_drive_odometry.sv =====
// Differential-drive dead-reckoning odometry, top level.
// Depends on odo_pkg, odo_ctrl and odo_datapath.
//
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one wheel report
// per item: left and right speed counts and the elapsed time in microseconds.
// Output channel (o_out_valid / i_out_ready / o_out_data) returns one pose
// item per report: x, y, heading, forward speed and turn rate.
// Configuration channel (i_cfg_valid / o_cfg_ready, index and data) writes
// wheel_gain (index 0) or half_track_recip (index 1); it is always ready.
// From input accept to output valid the controller makes eleven passes
// through the shared digit-serial multiplier and then commits the result;
// the fourth pass waits for the CORDIC, which starts at the accept and
// runs TRIG_ITERATIONS steps.
// Reports are taken one at a time: none is accepted while an item is in progress.
// The next report is accepted as soon as the result is written to the
// output register, even if that result has not yet been taken.
// If the receiver stalls, the finished pose waits in the output register and
// the following item stops before its commit until the register frees.
// Reset clears the pose to zero, restores the register defaults and drops
// any pending item.
module diff_drive_odometry #(
    parameter int SPEED_BITS      = 16,
    parameter int TRIG_ITERATIONS = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  odo_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output odo_pkg::t_out o_out_data,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [7:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data
);

    odo_pkg::t_cmd cmd;
    odo_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    odo_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    odo_datapath #(
        .SPEED_BITS      (SPEED_BITS),
        .TRIG_ITERATIONS (TRIG_ITERATIONS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in        (i_in_data),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out_data)
    );

endmodule

// ===== rtl/odo_checker.sv =====
// Port-level checks for the odometry block, bound to the top level.
// Depends on odo_pkg for the payload types.
module odo_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input odo_pkg::t_out o_out_data
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // One item at a time: ready drops after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted while busy");

    // No result appears straight after an accept
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !$rose(o_out_valid))
        else $error("result too early");

    // Reset empties the output
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind diff_drive_odometry odo_checker u_odo_checker (.*);

// ===== tb/sv/diff_drive_odometry_test.sv =====
// Self-checking testbench for the differential-drive odometry block.
// Depends on odo_pkg and diff_drive_odometry; predicts each pose item and
// compares it field by field with the block's output.
`timescale 1ns / 100ps

module diff_drive_odometry_test;

    localparam int SPEED_BITS      = 16;
    localparam int TRIG_ITERATIONS = 24;
    localparam int LATENCY         = 100;
    localparam int STALL_LIMIT     = 20000;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_in_valid;
    logic          o_in_ready;
    odo_pkg::t_in  i_in_data;
    logic          o_out_valid;
    logic          i_out_ready;
    odo_pkg::t_out o_out_data;
    logic          i_cfg_valid;
    logic          o_cfg_ready;
    logic [7:0]    i_cfg_index;
    logic [31:0]   i_cfg_data;

    // Predictor state and configuration
    logic [31:0]        gain_q32;
    logic [31:0]        track_recip_q24;
    logic signed [31:0] x_pos;
    logic signed [31:0] y_pos;
    logic [31:0]        heading;

    odo_pkg::t_out pose_queue[$];
    int   fail_count;
    int   idle_cycles;
    bit   out_stalls_on;

    diff_drive_odometry #(
        .SPEED_BITS     (SPEED_BITS),
        .TRIG_ITERATIONS(TRIG_ITERATIONS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Floor shift of a signed 64-bit value
    function automatic longint floor_shr(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end else if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Exact floor(p * c / 2^32), product formed in 16-bit halves
    function automatic longint scale_q32(input longint p, input longint c);
        longint hi;
        longint lo;
        hi = p >>> 16;
        lo = p & 64'hFFFF;
        return (hi * c + ((lo * c) >>> 16)) >>> 16;
    endfunction

    function automatic logic [31:0] arctan_angle(input int i);
        logic [31:0] t[32];
        t = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
              32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
              32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
              32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
              32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
              32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
              32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
              32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000};
        return t[i];
    endfunction

    // Rotation-mode CORDIC: cosine and sine of a binary angle in Q1.30
    function automatic void heading_trig(input logic [31:0] a, output longint cs,
                                         output longint sn);
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        bit     flip;
        z = a;
        x = 652032874;
        y = 0;
        flip = 0;
        if (z >= 64'sd2147483648) z = z - 64'sd4294967296;
        if (z > 64'sd1073741824) begin
            z = z - 64'sd2147483648;
            flip = 1;
        end else if (z < -64'sd1073741824) begin
            z = z + 64'sd2147483648;
            flip = 1;
        end
        for (int i = 0; i < TRIG_ITERATIONS && i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(arctan_angle(i));
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(arctan_angle(i));
            end
        end
        cs = flip ? -x : x;
        sn = flip ? -y : y;
    endfunction

    // Advance the pose by one wheel report and return the expected item
    function automatic odo_pkg::t_out advance_pose(input odo_pkg::t_in r);
        longint cl, cr, us, pl, pr, fwd, hd, tr, cs, sn, vc, vs, dx, dy, dth;
        odo_pkg::t_out o;
        cl = longint'($signed(r.left_wheel_speed));
        cr = longint'($signed(r.right_wheel_speed));
        us = longint'(r.elapsed_us);
        pl = cl * longint'(gain_q32);
        pr = cr * longint'(gain_q32);
        fwd = clamp32((pl + pr) >>> 17);
        hd = clamp32((pr - pl) >>> 17);
        tr = clamp32((hd * longint'(track_recip_q24)) >>> 24);
        heading_trig(heading, cs, sn);
        vc = (fwd * cs) >>> 30;
        vs = (fwd * sn) >>> 30;
        dx = scale_q32(vc * us, 4295);
        dy = scale_q32(vs * us, 4295);
        dth = scale_q32(tr * us, 44798134);
        x_pos = 32'(clamp32(longint'(x_pos) + dx));
        y_pos = 32'(clamp32(longint'(y_pos) + dy));
        heading = heading + 32'(dth);
        o.pos_x = x_pos;
        o.pos_y = y_pos;
        o.heading_angle = heading;
        o.forward_speed = 32'(fwd);
        o.turn_rate = 32'(tr);
        return o;
    endfunction

    // Send one wheel report after a random gap, predicting its pose
    task automatic send_report(input logic [15:0] l, input logic [15:0] r,
                               input logic [19:0] us);
        odo_pkg::t_in item;
        int           gap;
        item.left_wheel_speed = l;
        item.right_wheel_speed = r;
        item.elapsed_us = us;
        gap = $urandom_range(12);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= item;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pose_queue.push_back(advance_pose(item));
    endtask

    // Write one register once the block has drained
    task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
        i_in_valid <= 1'b0;
        while (pose_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == odo_pkg::CFG_WHEEL_GAIN) gain_q32 = val;
        else track_recip_q24 = val;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] random_count();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(200)) - 16'd100;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [19:0] random_interval();
        case ($urandom_range(7))
            0: return 20'd0;
            1: return 20'hFFFFF;
            2: return 20'($urandom);
            default: return 20'($urandom_range(20000));
        endcase
    endfunction

    // Extremes of every field, zero interval, straight runs and turns
    task automatic test_directed();
        send_report(16'd0, 16'd0, 20'd0);
        send_report(16'd100, 16'd100, 20'd0);
        send_report(16'd100, 16'd100, 20'd10000);
        send_report(16'h7FFF, 16'h7FFF, 20'hFFFFF);
        send_report(16'h8000, 16'h8000, 20'hFFFFF);
        send_report(16'h8000, 16'h7FFF, 20'hFFFFF);
        send_report(16'h7FFF, 16'h8000, 20'hFFFFF);
        send_report(16'hFFFF, 16'h0001, 20'd1);
        send_report(16'h5555, 16'hAAAA, 20'h55555);
        send_report(16'hAAAA, 16'h5555, 20'hAAAAA);
        for (int i = 0; i < 8; i++) send_report(16'h8000, 16'h7FFF, 20'hFFFFF);
    endtask

    // Pin positions against saturation with large gain and long intervals
    task automatic test_saturation();
        write_reg(odo_pkg::CFG_WHEEL_GAIN, 32'hFFFFFFFF);
        write_reg(odo_pkg::CFG_HALF_TRACK, 32'h0);
        for (int i = 0; i < 40; i++) send_report(16'h7FFF, 16'h7FFF, 20'hFFFFF);
        for (int i = 0; i < 40; i++) send_report(16'h8000, 16'h8000, 20'hFFFFF);
        write_reg(odo_pkg::CFG_HALF_TRACK, 32'hFFFFFFFF);
        for (int i = 0; i < 20; i++) send_report(random_count(), random_count(), 20'hFFFFF);
    endtask

    // Random reports; test_settings runs them across several register settings
    task automatic test_random(input int n);
        for (int i = 0; i < n; i++) begin
            send_report(random_count(), random_count(), random_interval());
        end
    endtask

    task automatic test_settings();
        write_reg(odo_pkg::CFG_WHEEL_GAIN, odo_pkg::WHEEL_GAIN_RST);
        write_reg(odo_pkg::CFG_HALF_TRACK, odo_pkg::HALF_TRACK_RST);
        test_random(700);
        write_reg(odo_pkg::CFG_WHEEL_GAIN, 32'h0);
        test_random(60);
        write_reg(odo_pkg::CFG_WHEEL_GAIN, $urandom);
        write_reg(odo_pkg::CFG_HALF_TRACK, $urandom);
        out_stalls_on = 0;
        test_random(300);
        out_stalls_on = 1;
        write_reg(odo_pkg::CFG_WHEEL_GAIN, 32'h10000000);
        write_reg(odo_pkg::CFG_HALF_TRACK, 32'h01000000);
        test_random(680);
    endtask

    // Receiver: random stalls while out_stalls_on is set, then take one item
    initial begin
        int gap;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            gap = out_stalls_on ? $urandom_range(12) : 0;
            if (gap != 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    // Compare each accepted pose item with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pose_queue.size() == 0) begin
                $display("%0t: unexpected pose item %h", $time, o_out_data);
                fail_count++;
            end else begin
                automatic odo_pkg::t_out e = pose_queue.pop_front();
                if (o_out_data.pos_x !== e.pos_x) begin
                    $display("%0t: pos_x expected %0d actual %0d", $time, e.pos_x,
                             o_out_data.pos_x);
                    fail_count++;
                end
                if (o_out_data.pos_y !== e.pos_y) begin
                    $display("%0t: pos_y expected %0d actual %0d", $time, e.pos_y,
                             o_out_data.pos_y);
                    fail_count++;
                end
                if (o_out_data.heading_angle !== e.heading_angle) begin
                    $display("%0t: heading_angle expected %h actual %h", $time,
                             e.heading_angle, o_out_data.heading_angle);
                    fail_count++;
                end
                if (o_out_data.forward_speed !== e.forward_speed) begin
                    $display("%0t: forward_speed expected %0d actual %0d", $time,
                             e.forward_speed, o_out_data.forward_speed);
                    fail_count++;
                end
                if (o_out_data.turn_rate !== e.turn_rate) begin
                    $display("%0t: turn_rate expected %0d actual %0d", $time,
                             e.turn_rate, o_out_data.turn_rate);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: count cycles without any accepted item
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        fail_count = 0;
        idle_cycles = 0;
        out_stalls_on = 1;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = odo_pkg::CFG_WHEEL_GAIN;
        i_cfg_data = '0;
        gain_q32 = odo_pkg::WHEEL_GAIN_RST;
        track_recip_q24 = odo_pkg::HALF_TRACK_RST;
        x_pos = '0;
        y_pos = '0;
        heading = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_saturation();
        test_settings();
        i_in_valid <= 1'b0;
        while (pose_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
        if (fail_count == 0 && pose_queue.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
